// ----- rtl/incremental_speed_pi_ramped_defines.svh -----
// assertion macros for the speed pi controller
`ifndef INCREMENTAL_SPEED_PI_RAMPED_DEFINES_SVH
`define INCREMENTAL_SPEED_PI_RAMPED_DEFINES_SVH
`ifndef SYNTHESIS
`define ISP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ISP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ISP_ASSERT_IMP(label, clk, rst, ante, cons)
`define ISP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/isp_pkg.sv -----
// shared types and constants of the speed pi controller
`default_nettype none
package isp_pkg;

  localparam int ISP_UPDATE_PERIOD = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SPEED_W = 12;
  localparam int ERR_W   = 13;
  localparam int LOOP_W  = 19;
  localparam int DIFF_W  = 20;
  localparam int DRIVE_W = 27;
  localparam int STEP_W  = 28;
  localparam int PROD_W  = 29;

  localparam int LOOP_LIM = 256000;
  localparam logic signed [LOOP_W-1:0]  LOOP_MAX  = 19'sd255999;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 27'sd65536000;
  localparam logic signed [ERR_W-1:0]   ERROR_CAP = 13'sd20;
  localparam logic [16:0] BOOST_GAIN = 17'd512;
  localparam logic [15:0] BOOST_TIME = 16'd200;

  localparam logic [15:0] PROP_GAIN_RST      = 16'd9856;
  localparam logic [15:0] INTEGRAL_GAIN_RST  = 16'd819;
  localparam logic [10:0] SPEED_TARGET_RST   = 11'd85;
  localparam logic [10:0] INTEGRAL_LIMIT_RST = 11'd9;
  localparam logic [10:0] SLOPE_OUTPUT_RST   = 11'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEGRAL_GAIN  = 3'd1,
    REG_SPEED_TARGET   = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_SLOPE_ENABLE   = 3'd4,
    REG_SLOPE_OUTPUT   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_fix;
  } div_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/isp_ramp_div.sv -----
// two-stage signed divide of the ramp delta by the update period
`default_nettype none
module isp_ramp_div import isp_pkg::*; #(
  parameter int UPDATE_PERIOD = ISP_UPDATE_PERIOD
) (
  input  wire logic                     clk,
  input  wire div_ctl_t                 ctl,
  input  wire logic signed [DIFF_W-1:0] diff,
  output logic signed [STEP_W-1:0]      step
);

  localparam int MAG_W   = DIFF_W - 1;
  localparam int Q_W     = MAG_W + 8;
  localparam int SHIFT   = Q_W;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_FW = MAG_W + RECIP_W;
  localparam int PER_W   = $clog2(UPDATE_PERIOD + 1);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / UPDATE_PERIOD);
  localparam logic [PER_W-1:0]   PER   = PER_W'(UPDATE_PERIOD);

  logic [MAG_W-1:0]   mag_in;
  logic [PROD_FW-1:0] prod;
  logic [MAG_W-1:0]   mag;
  logic               neg;
  logic [Q_W-1:0]     q_est;
  logic [Q_W-1:0]     num;
  logic [Q_W-1:0]     q_times_p;
  logic [Q_W-1:0]     rem;
  logic [Q_W-1:0]     quot;
  logic signed [STEP_W-1:0] step_next;

  // estimate is low by at most one
  always_comb begin
    mag_in = MAG_W'(diff[DIFF_W-1] ? -diff : diff);
    prod   = PROD_FW'(mag_in) * PROD_FW'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      mag   <= mag_in;
      neg   <= diff[DIFF_W-1];
      q_est <= prod[SHIFT-8+Q_W-1:SHIFT-8];
    end
  end

  always_comb begin
    num       = {mag, 8'b0};
    q_times_p = Q_W'(q_est * PER);
    rem       = num - q_times_p;
    quot      = (rem >= Q_W'(PER)) ? q_est + Q_W'(1) : q_est;
    step_next = neg ? -signed'(STEP_W'(quot)) : signed'(STEP_W'(quot));
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_fix) begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/incremental_speed_pi_ramped.sv -----
// top level: incremental speed pi controller with ramped drive output
//
// one input item is one control tick: wheel speeds and run, stop, elapsed
// and slope-hold flags. every item gives exactly one result item carrying
// the ramped drive (Q11.16) and the current loop output (Q11.8).
// input and result channels use valid/ready; config writes arrive on their
// own valid/ready channel (index, data) and are always taken.
// the datapath is a six-stage pipeline: input register, error and gain
// products, loop accumulate and saturate, two divider stages for the ramp
// step, and the drive accumulator that is also the result register.
// one item is taken every cycle while the receiver is ready, set by the
// single pass through each stage.
// each stage holds its item until the next stage frees, so a stalled
// receiver fills the pipeline bubble by bubble before input ready drops.
// reset clears the phase counter, error, loop and drive state, restores the
// register defaults and empties the pipeline.
`default_nettype none
`include "incremental_speed_pi_ramped_defines.svh"
module incremental_speed_pi_ramped import isp_pkg::*; #(
  parameter int UPDATE_PERIOD = ISP_UPDATE_PERIOD
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [SPEED_W-1:0] speed_left,
  input  wire logic signed [SPEED_W-1:0] speed_right,
  input  wire logic                      run_on,
  input  wire logic                      stop_on,
  input  wire logic [15:0]               elapsed_ticks,
  input  wire logic                      slope_hold,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [DRIVE_W-1:0]      drive_out,
  output logic signed [LOOP_W-1:0]       loop_out,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int PHASE_W = $clog2(UPDATE_PERIOD + 1);
  localparam int SUM_W   = PROD_W + 2;

  // config registers
  logic [15:0]        prop_gain;
  logic [15:0]        integral_gain;
  logic [10:0]        speed_target;
  logic [10:0]        integral_limit;
  logic               slope_enable;
  logic signed [10:0] slope_output;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= PROP_GAIN_RST;
      integral_gain  <= INTEGRAL_GAIN_RST;
      speed_target   <= SPEED_TARGET_RST;
      integral_limit <= INTEGRAL_LIMIT_RST;
      slope_enable   <= 1'b0;
      slope_output   <= signed'(SLOPE_OUTPUT_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:      prop_gain      <= cfg_data;
        REG_INTEGRAL_GAIN:  integral_gain  <= cfg_data;
        REG_SPEED_TARGET:   speed_target   <= cfg_data[10:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[10:0];
        REG_SLOPE_ENABLE:   slope_enable   <= cfg_data[0];
        REG_SLOPE_OUTPUT:   slope_output   <= signed'(cfg_data[10:0]);
        default: ;
      endcase
    end
  end

  // pipeline occupancy and flow
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;
  logic s3_load;

  assign en6      = !v6 || out_ready;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign s3_load  = v2 && en3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // stage 1: input register and tick phase
  logic [PHASE_W-1:0]        phase;
  logic [PHASE_W-1:0]        phase_inc;
  logic                      at_period;
  logic                      tick_act;
  logic signed [SPEED_W-1:0] s1_left;
  logic signed [SPEED_W-1:0] s1_right;
  logic                      s1_stop;
  logic                      s1_early;
  logic                      s1_hold;
  logic                      s1_act;
  logic                      s1_upd;

  assign phase_inc = phase + PHASE_W'(1);
  assign at_period = (phase_inc == PHASE_W'(UPDATE_PERIOD));
  assign tick_act  = run_on || stop_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (in_valid && en1) begin
      phase <= at_period ? '0 : phase_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_left  <= speed_left;
      s1_right <= speed_right;
      s1_stop  <= stop_on;
      s1_early <= (elapsed_ticks < BOOST_TIME);
      s1_hold  <= slope_hold;
      s1_act   <= tick_act;
      s1_upd   <= tick_act && at_period;
    end
  end

  // stage 2: error, gain selection and products
  logic signed [ERR_W-1:0]  prev_error;
  logic signed [ERR_W-1:0]  spd_sum;
  logic signed [ERR_W-1:0]  spd_rnd;
  logic signed [ERR_W-1:0]  spd_avg;
  logic signed [ERR_W-1:0]  tgt;
  logic signed [ERR_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-2:0]         err_mag;
  logic signed [ERR_W:0]    err_diff;
  logic                     boost;
  logic [16:0]              p_gain;
  logic [16:0]              i_gain;
  logic signed [PROD_W-1:0] p_prod;
  logic signed [PROD_W-1:0] i_prod;
  logic signed [PROD_W-1:0] s2_pterm;
  logic signed [PROD_W-1:0] s2_iterm;
  logic                     s2_act;
  logic                     s2_upd;
  logic                     s2_force;

  always_comb begin
    spd_sum  = ERR_W'(s1_left) + ERR_W'(s1_right);
    spd_rnd  = spd_sum[ERR_W-1] ? 13'sd1 : 13'sd0;
    spd_avg  = (spd_sum + spd_rnd) >>> 1;
    tgt      = s1_stop ? '0 : signed'({2'b00, speed_target});
    err_raw  = tgt - spd_avg;
    err      = (err_raw > ERROR_CAP) ? ERROR_CAP : err_raw;
    err_mag  = (ERR_W - 1)'(err[ERR_W-1] ? -err : err);
    err_diff = (ERR_W + 1)'(err) - (ERR_W + 1)'(prev_error);
    boost    = s1_early || s1_stop;
    if (boost) begin
      p_gain = 17'(prop_gain) + BOOST_GAIN;
      i_gain = 17'(integral_gain) + BOOST_GAIN;
    end else begin
      p_gain = 17'(prop_gain);
      i_gain = (err_mag > (ERR_W - 1)'(integral_limit)) ? '0 : 17'(integral_gain);
    end
    p_prod = signed'({1'b0, p_gain}) * err_diff;
    i_prod = signed'({1'b0, i_gain}) * err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
    end else if (v1 && en2 && s1_upd) begin
      prev_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_pterm <= p_prod;
      s2_iterm <= i_prod;
      s2_act   <= s1_act;
      s2_upd   <= s1_upd;
      s2_force <= slope_enable && s1_hold;
    end
  end

  // stage 3: loop accumulate, override and saturate
  logic signed [LOOP_W-1:0] loop_acc;
  logic signed [LOOP_W-1:0] loop_before;
  logic signed [SUM_W-1:0]  acc_sum;
  logic signed [SUM_W-1:0]  slope_val;
  logic signed [SUM_W-1:0]  acc_pre;
  logic signed [LOOP_W-1:0] loop_sat;
  logic signed [DIFF_W-1:0] diff_next;
  logic signed [DIFF_W-1:0] s3_diff;
  logic signed [LOOP_W-1:0] s3_loop;
  logic                     s3_act;

  always_comb begin
    acc_sum   = SUM_W'(loop_acc) + SUM_W'(s2_pterm) + SUM_W'(s2_iterm);
    slope_val = {{(SUM_W - 19){slope_output[10]}}, slope_output, 8'b0};
    acc_pre   = s2_force ? slope_val : acc_sum;
    if (acc_pre >= SUM_W'(LOOP_LIM)) begin
      loop_sat = LOOP_MAX;
    end else if (acc_pre <= -SUM_W'(LOOP_LIM)) begin
      loop_sat = -LOOP_MAX;
    end else begin
      loop_sat = acc_pre[LOOP_W-1:0];
    end
    if (s2_upd) begin
      diff_next = DIFF_W'(loop_sat) - DIFF_W'(loop_acc);
    end else begin
      diff_next = DIFF_W'(loop_acc) - DIFF_W'(loop_before);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_acc    <= '0;
      loop_before <= '0;
    end else if (s3_load && s2_upd) begin
      loop_acc    <= loop_sat;
      loop_before <= loop_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_diff <= diff_next;
      s3_loop <= s2_upd ? loop_sat : loop_acc;
      s3_act  <= s2_act;
    end
  end

  // stages 4 and 5: ramp step
  div_ctl_t                 div_ctl;
  logic signed [STEP_W-1:0] ramp_step;
  logic signed [LOOP_W-1:0] s4_loop;
  logic                     s4_act;
  logic signed [LOOP_W-1:0] s5_loop;
  logic                     s5_act;

  assign div_ctl.ld_mul = en4;
  assign div_ctl.ld_fix = en5;

  isp_ramp_div #(
    .UPDATE_PERIOD(UPDATE_PERIOD)
  ) u_ramp_div (
    .clk  (clk),
    .ctl  (div_ctl),
    .diff (s3_diff),
    .step (ramp_step)
  );

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_loop <= s3_loop;
      s4_act  <= s3_act;
    end
    if (en5) begin
      s5_loop <= s4_loop;
      s5_act  <= s4_act;
    end
  end

  // stage 6: drive accumulator and result register
  logic signed [DRIVE_W-1:0] drive_acc;
  logic signed [DRIVE_W+1:0] drive_sum;
  logic signed [DRIVE_W-1:0] drive_next;
  logic signed [LOOP_W-1:0]  s6_loop;

  always_comb begin
    drive_sum = (DRIVE_W + 2)'(drive_acc) + (DRIVE_W + 2)'(ramp_step);
    if (drive_sum > (DRIVE_W + 2)'(DRIVE_MAX)) begin
      drive_next = DRIVE_MAX;
    end else if (drive_sum < -(DRIVE_W + 2)'(DRIVE_MAX)) begin
      drive_next = -DRIVE_MAX;
    end else begin
      drive_next = drive_sum[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_acc <= '0;
    end else if (v5 && en6 && s5_act) begin
      drive_acc <= drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_loop <= s5_loop;
    end
  end

  assign out_valid = v6;
  assign drive_out = drive_acc;
  assign loop_out  = s6_loop;

  `ISP_ASSERT_NXT(a_phase_wrap, clk, rst, in_valid && in_ready && at_period, phase == '0)
  `ISP_ASSERT_NXT(a_loop_hold, clk, rst, !(s3_load && s2_upd), $stable(loop_acc) && $stable(loop_before))
  `ISP_ASSERT_IMP(a_out_range, clk, rst, out_valid, (s6_loop <= LOOP_MAX) && (s6_loop >= -LOOP_MAX) && (drive_acc <= DRIVE_MAX) && (drive_acc >= -DRIVE_MAX))

endmodule
`default_nettype wire
